FILE: rtl/vsm_pkg.sv
// ----------------------------------------------------------------------------
// vsm_pkg
// shared constants for the planar sobel maximum gradient unit
// ----------------------------------------------------------------------------
`default_nettype none

package vsm_pkg;

	localparam int PIX_W     = 8;
	localparam int GRAD_W    = 10;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_TD_W  = 16;

	localparam logic CMD_DATA  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/volume_sobel_max_magnitude_unit.sv
// ----------------------------------------------------------------------------
// volume_sobel_max_magnitude_unit
// 3d planar sobel maximum gradient over a streamed 8-bit volume
// ----------------------------------------------------------------------------
// result path: an item's result is held in the s1 stage, then in the result register
// throughput: one item per cycle while the receiver does not stall the output,
//   set by the single write/read port of each frame and line ram that advances once per voxel
// reset: asynchronous, clears registers to defaults, positions and counts;
//   the frame and line rams keep their contents and need no clearing pass
`default_nettype none

module volume_sobel_max_magnitude_unit import vsm_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [PIX_W-1:0]     s_axis_tdata,   // voxel
	input  wire logic                 s_axis_tuser,   // command
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic      [OUT_TD_W-1:0]  m_axis_tdata,   // gradient, zero fill
	output logic                      m_axis_tlast,   // last
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int FR_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int FAW      = $clog2(FR_DEPTH);
	localparam int LAW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW       = $clog2(MAX_WIDTH);
	localparam int RW       = $clog2(MAX_HEIGHT);
	localparam int PEND_W   = $clog2(FR_DEPTH + MAX_WIDTH + 2);
	localparam int DIM_W    = 9;
	localparam int DEP_W    = 16;
	localparam int WH_W     = 2 * DIM_W;
	localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
	localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
		logic [DIM_W-1:0] r;
		r = v;
		if (v < DIM_W'(3)) r = DIM_W'(3);
		if (32'(v) > hi) r = DIM_W'(hi);
		return r;
	endfunction

	function automatic logic [GRAD_W-1:0] sob(
		input logic [PIX_W-1:0] p0, input logic [PIX_W-1:0] p1, input logic [PIX_W-1:0] p2,
		input logic [PIX_W-1:0] m0, input logic [PIX_W-1:0] m1, input logic [PIX_W-1:0] m2
	);
		logic signed [11:0] s;
		s = $signed({4'b0, p0}) - $signed({4'b0, m0})
			+ 12'sd2 * ($signed({4'b0, p1}) - $signed({4'b0, m1}))
			+ $signed({4'b0, p2}) - $signed({4'b0, m2});
		return (s < 0) ? GRAD_W'(-s) : GRAD_W'(s);
	endfunction

	function automatic logic [GRAD_W-1:0] max2(input logic [GRAD_W-1:0] a,
		input logic [GRAD_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	logic [DIM_W-1:0] vol_width_q;
	logic [DIM_W-1:0] vol_height_q;
	logic [DEP_W-1:0] vol_depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_width_q  <= RST_WIDTH;
			vol_height_q <= RST_HEIGHT;
			vol_depth_q  <= DEP_W'(3);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  vol_width_q  <= clamp_dim(cfg_data[DIM_W-1:0], MAX_WIDTH);
				REG_HEIGHT: vol_height_q <= clamp_dim(cfg_data[DIM_W-1:0], MAX_HEIGHT);
				REG_DEPTH:  vol_depth_q  <= (cfg_data < DEP_W'(3)) ? DEP_W'(3) : cfg_data;
				default: ;
			endcase
		end
	end

	logic              restart;
	logic [WH_W-1:0]   wh;
	logic [PEND_W-1:0] lag;
	logic [FAW-1:0]    fr_len;
	logic [LAW-1:0]    ln_len;

	assign restart = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
		|| cfg_index == REG_DEPTH);
	assign wh      = vol_width_q * vol_height_q;
	assign lag     = PEND_W'(wh) + PEND_W'(vol_width_q) + PEND_W'(1);
	assign fr_len  = FAW'(wh - WH_W'(1));
	assign ln_len  = LAW'(vol_width_q - DIM_W'(1));

	// input handshake and result control
	logic              s1_v;
	logic              s1_zero;
	logic              s1_last;
	logic              s2_free;
	logic              in_acc;
	logic              is_data;
	logic              has_res;
	logic              interior;
	logic              last_pos;
	logic [PEND_W-1:0] pending_q;
	logic [PEND_W-1:0] pend_inc;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [DEP_W-1:0]  frm_q;

	assign s2_free       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !s1_v || s2_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign is_data       = (s_axis_tuser == CMD_DATA);
	assign pend_inc      = pending_q + PEND_W'(1);
	assign has_res       = is_data ? (pend_inc > lag) : (pending_q != '0);

	assign interior = (col_q != '0) && (DIM_W'(col_q) + DIM_W'(2) <= vol_width_q)
		&& (row_q != '0) && (DIM_W'(row_q) + DIM_W'(2) <= vol_height_q)
		&& (frm_q != '0) && (17'(frm_q) + 17'd2 <= 17'(vol_depth_q));
	assign last_pos = (DIM_W'(col_q) + DIM_W'(1) == vol_width_q)
		&& (DIM_W'(row_q) + DIM_W'(1) == vol_height_q)
		&& (17'(frm_q) + 17'd1 == 17'(vol_depth_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
			frm_q     <= '0;
		end else if (restart) begin
			pending_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
			frm_q     <= '0;
		end else if (in_acc) begin
			if (is_data && !has_res) begin
				pending_q <= pend_inc;
			end else if (!is_data && has_res) begin
				pending_q <= pending_q - PEND_W'(1);
			end
			if (has_res) begin
				if (DIM_W'(col_q) + DIM_W'(1) >= vol_width_q) begin
					col_q <= '0;
					if (DIM_W'(row_q) + DIM_W'(1) >= vol_height_q) begin
						row_q <= '0;
						if (17'(frm_q) + 17'd1 >= 17'(vol_depth_q)) begin
							frm_q <= '0;
						end else begin
							frm_q <= frm_q + DEP_W'(1);
						end
					end else begin
						row_q <= row_q + RW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (s_axis_tready) begin
			s1_v <= in_acc && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_zero <= !is_data || !interior;
			s1_last <= last_pos;
		end
	end

	// voxel window: frame delays, line delays, column taps
	logic             shift_en;
	logic [PIX_W-1:0] x0_q;
	logic [PIX_W-1:0] ystr [3][3];
	logic [PIX_W-1:0] col1_q [3][3];
	logic [PIX_W-1:0] col2_q [3][3];
	logic [PIX_W-1:0] win [3][3][3];

	assign shift_en = in_acc && is_data;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			x0_q <= s_axis_tdata;
		end
	end

	assign ystr[0][0] = x0_q;

	for (genvar c = 1; c < 3; c++) begin : g_frame
		vsm_delay #(
			.DEPTH(FR_DEPTH)
		) u_frame (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (shift_en),
			.clr   (restart),
			.len   (fr_len),
			.din   (ystr[c-1][0]),
			.dout  (ystr[c][0])
		);
	end

	for (genvar c = 0; c < 3; c++) begin : g_plane
		for (genvar b = 1; b < 3; b++) begin : g_line
			vsm_delay #(
				.DEPTH(MAX_WIDTH)
			) u_line (
				.clk   (clk),
				.arst_n(arst_n),
				.en    (shift_en),
				.clr   (restart),
				.len   (ln_len),
				.din   (ystr[c][b-1]),
				.dout  (ystr[c][b])
			);
		end
		for (genvar b = 0; b < 3; b++) begin : g_col
			always_ff @(posedge clk) begin
				if (shift_en) begin
					col1_q[c][b] <= ystr[c][b];
					col2_q[c][b] <= col1_q[c][b];
				end
			end
			assign win[c][b][0] = ystr[c][b];
			assign win[c][b][1] = col1_q[c][b];
			assign win[c][b][2] = col2_q[c][b];
		end
	end

	// six planar responses and their maximum
	logic [GRAD_W-1:0] g_xy_x, g_xy_y, g_xz_x, g_xz_z, g_yz_y, g_yz_z;
	logic [GRAD_W-1:0] g_max;

	always_comb begin
		g_xy_x = sob(win[1][2][0], win[1][1][0], win[1][0][0],
			win[1][2][2], win[1][1][2], win[1][0][2]);
		g_xy_y = sob(win[1][0][2], win[1][0][1], win[1][0][0],
			win[1][2][2], win[1][2][1], win[1][2][0]);
		g_xz_x = sob(win[2][1][0], win[1][1][0], win[0][1][0],
			win[2][1][2], win[1][1][2], win[0][1][2]);
		g_xz_z = sob(win[0][1][2], win[0][1][1], win[0][1][0],
			win[2][1][2], win[2][1][1], win[2][1][0]);
		g_yz_z = sob(win[0][2][1], win[0][1][1], win[0][0][1],
			win[2][2][1], win[2][1][1], win[2][0][1]);
		g_yz_y = sob(win[2][0][1], win[1][0][1], win[0][0][1],
			win[2][2][1], win[1][2][1], win[0][2][1]);
		g_max = max2(max2(max2(g_xy_x, g_xy_y), max2(g_xz_x, g_xz_z)),
			max2(g_yz_y, g_yz_z));
	end

	// result register
	logic [GRAD_W-1:0] grad_s2;
	logic              last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (s2_free) begin
			m_axis_tvalid <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_v) begin
			grad_s2 <= s1_zero ? '0 : g_max;
			last_s2 <= s1_last;
		end
	end

	assign m_axis_tdata = {{(OUT_TD_W - GRAD_W){1'b0}}, grad_s2};
	assign m_axis_tlast = last_s2;

endmodule

`default_nettype wire

FILE: rtl/vsm_ram.sv
// ----------------------------------------------------------------------------
// vsm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module vsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/vsm_delay.sv
// ----------------------------------------------------------------------------
// vsm_delay
// programmable ring delay line between two registered voxel streams
// ----------------------------------------------------------------------------
`default_nettype none

module vsm_delay import vsm_pkg::*; #(
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             clr,
	input  wire logic [AW-1:0]    len,
	input  wire logic [PIX_W-1:0] din,
	output logic      [PIX_W-1:0] dout
);

	logic [AW-1:0] ptr_q;
	logic [AW-1:0] ptr_next;

	assign ptr_next = (ptr_q == len - AW'(1)) ? '0 : ptr_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (clr) begin
			ptr_q <= '0;
		end else if (en) begin
			ptr_q <= ptr_next;
		end
	end

	vsm_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (en),
		.waddr(ptr_q),
		.wdata(din),
		.re   (en),
		.raddr(ptr_q),
		.rdata(dout)
	);

endmodule

`default_nettype wire

FILE: dv/volume_sobel_max_magnitude_unit_tb.sv
// ----------------------------------------------------------------------------
// volume_sobel_max_magnitude_unit_tb
// Streams small and extreme volumes through the planar sobel maximum gradient
// unit and checks every result against a bit-true predictor or a typed value
// from the directed table. The sender works in bursts with gaps and the
// receiver stalls on its own pattern. The volume sizes are reprogrammed
// between phases, with the extremes and clamped values among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module volume_sobel_max_magnitude_unit_tb import vsm_pkg::*; ();

	localparam int          MAXW      = 256;
	localparam int          MAXH      = 256;
	localparam int unsigned STORE_SZ  = 2 * MAXW * MAXH + 2 * MAXW + 3;
	localparam int          IDLE_LIM  = 20000;
	localparam int          ITEM_GOAL = 1800;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef enum logic [1:0] {EXP_NONE, EXP_TYPED, EXP_PRED} exp_kind_t;

	typedef struct packed {
		logic              cmd;
		logic [PIX_W-1:0]  vox;
		exp_kind_t         kind;
		logic [GRAD_W-1:0] grad;
		logic              lst;
	} dir_row_t;

	typedef struct packed {
		logic [GRAD_W-1:0] grad;
		logic              lst;
	} grad_res_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [PIX_W-1:0]     s_axis_tdata;   // voxel
	logic                 s_axis_tuser;   // command
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_TD_W-1:0]  m_axis_tdata;   // gradient, zero fill
	logic                 m_axis_tlast;   // last
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	volume_sobel_max_magnitude_unit #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	bit [7:0]    vstore [STORE_SZ];
	int unsigned wr_ptr, pend, center;
	int unsigned col, row, frm;
	int unsigned vw, vh, vd;

	grad_res_t   grad_q [$];
	int          errors, n_items, n_results, n_rand, n_phases, burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int px(int dx, int dy, int dz);
		longint d, a;
		d = dx + dy * longint'(vw) + dz * longint'(vw) * longint'(vh);
		a = (longint'(center) + d) % longint'(STORE_SZ);
		if (a < 0) a += STORE_SZ;
		return int'(vstore[a]);
	endfunction

	function automatic int unsigned sobel_mag(int a, int b);
		int sum, w;
		int p [3];
		int m [3];
		sum = 0;
		for (int t = -1; t <= 1; t++) begin
			w = (t == 0) ? 2 : 1;
			p = '{0, 0, 0};
			m = '{0, 0, 0};
			p[a] = 1;
			m[a] = -1;
			p[b] = t;
			m[b] = t;
			sum += w * (px(p[0], p[1], p[2]) - px(m[0], m[1], m[2]));
		end
		return (sum < 0) ? -sum : sum;
	endfunction

	function automatic int unsigned max_u(int unsigned a, int unsigned b);
		return (a > b) ? a : b;
	endfunction

	task automatic grad_model(input logic cmd, input logic [7:0] vox,
			output bit has, output grad_res_t res);
		int unsigned lag, newest, gv;
		has = 0;
		res = '0;
		gv = 0;
		lag = vw * vh + vw + 1;
		if (cmd == CMD_DATA) begin
			vstore[wr_ptr] = vox;
			newest = wr_ptr;
			wr_ptr = (wr_ptr + 1) % STORE_SZ;
			pend++;
			if (pend <= lag) return;
			center = (newest + STORE_SZ - (pend - 1)) % STORE_SZ;
			if (col >= 1 && col + 2 <= vw && row >= 1 && row + 2 <= vh &&
					frm >= 1 && frm + 2 <= vd) begin
				gv = max_u(sobel_mag(0, 1), sobel_mag(1, 0));
				gv = max_u(gv, max_u(sobel_mag(0, 2), sobel_mag(2, 0)));
				gv = max_u(gv, max_u(sobel_mag(2, 1), sobel_mag(1, 2)));
			end
		end else if (pend == 0) begin
			return;
		end
		has = 1;
		res.grad = gv[GRAD_W-1:0];
		res.lst = (col + 1 == vw && row + 1 == vh && frm + 1 == vd);
		pend--;
		col++;
		if (col >= vw) begin
			col = 0;
			row++;
			if (row >= vh) begin
				row = 0;
				frm++;
				if (frm >= vd) frm = 0;
			end
		end
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_WIDTH:  vw = clamp_u(val & 16'h01FF, 3, MAXW);
			REG_HEIGHT: vh = clamp_u(val & 16'h01FF, 3, MAXH);
			REG_DEPTH:  vd = clamp_u(val, 3, 65535);
			default:    ;
		endcase
		if (idx != REG_NONE) begin
			pend = 0;
			col = 0;
			row = 0;
			frm = 0;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// drives one item in bursts with gaps; acceptance is judged from values
	// sampled mid-cycle
	task automatic send_item(input logic cmd, input logic [7:0] vox,
			input exp_kind_t kind, input grad_res_t typed);
		bit ok, has;
		grad_res_t res;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 16);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= vox;
		do begin
			@(negedge clk);
			ok = s_axis_tready;
			@(posedge clk);
		end while (!ok);
		burst_left--;
		n_items++;
		grad_model(cmd, vox, has, res);
		if (kind == EXP_TYPED)
			grad_q.push_back(typed);
		else if (kind == EXP_PRED && has)
			grad_q.push_back(res);
	endtask

	task automatic drain_all(input int extra);
		int n;
		n = pend + extra;
		for (int i = 0; i < n; i++) send_item(CMD_FLUSH, 8'($urandom), EXP_PRED, '0);
		s_axis_tvalid <= 1'b0;
		while (grad_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_voxel(int mode, logic [7:0] base);
		case (mode)
			0:       return 8'($urandom);
			1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: return base + 8'($urandom_range(0, 7));
		endcase
	endfunction

	// one configuration and a stream of volumes, then drained empty
	task automatic run_phase(input logic [CFG_W-1:0] wr, input logic [CFG_W-1:0] hr,
			input logic [CFG_W-1:0] dr, input int nvol, input int cap, input bit rnd);
		int total, mode;
		longint tot;
		logic [7:0] base;
		cfg_write(REG_WIDTH, wr);
		cfg_write(REG_HEIGHT, hr);
		cfg_write(REG_DEPTH, dr);
		n_phases++;
		tot = longint'(vw) * longint'(vh) * longint'(vd) * longint'(nvol);
		if (tot > cap) tot = cap;
		total = int'(tot);
		mode = $urandom_range(0, 2);
		base = 8'($urandom);
		for (int i = 0; i < total; i++) begin
			if ($urandom_range(0, 49) == 0) begin
				send_item(CMD_FLUSH, 8'($urandom), EXP_PRED, '0);
				if (rnd) n_rand++;
			end
			send_item(CMD_DATA, pick_voxel(mode, base), EXP_PRED, '0);
			if (rnd) n_rand++;
		end
		drain_all($urandom_range(0, 2));
	endtask

	// receiver stall pattern
	int rx_cnt;
	int rx_mode;
	always @(posedge clk) begin
		if (rx_cnt == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_cnt <= $urandom_range(20, 300);
		end else begin
			rx_cnt <= rx_cnt - 1;
		end
		case (rx_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= 1'($urandom);
			default: m_axis_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// result checker
	always @(negedge clk) begin
		grad_res_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (grad_q.size() == 0) begin
				$error("unexpected result gradient=%0d last=%0b", m_axis_tdata[GRAD_W-1:0],
					m_axis_tlast);
				errors++;
			end else begin
				e = grad_q.pop_front();
				if (m_axis_tdata[GRAD_W-1:0] !== e.grad) begin
					$error("gradient expected %0d actual %0d", e.grad,
						m_axis_tdata[GRAD_W-1:0]);
					errors++;
				end
				if (m_axis_tlast !== e.lst) begin
					$error("last expected %0b actual %0b", e.lst, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	int idle_cnt;
	always @(negedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| cfg_we) begin
			idle_cnt <= 0;
		end else begin
			idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= IDLE_LIM) begin
				$display("watchdog expired with %0d results outstanding", grad_q.size());
				$display("volume_sobel_max_magnitude_unit_tb: FAIL");
				$finish;
			end
		end
	end

	dir_row_t dir_tab [25];

	initial begin
		grad_res_t typed;
		int left, cap;
		dir_tab = '{
			'{CMD_FLUSH, 8'h00, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'hFF, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'h00, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'hFF, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'h00, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'h80, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'h7F, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'hFF, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'hFF, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'h00, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'h00, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'hFF, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'h00, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'h55, EXP_NONE, 10'd0, 1'b0},
			'{CMD_DATA,  8'hAA, EXP_TYPED, 10'd0, 1'b0},
			'{CMD_FLUSH, 8'hFF, EXP_TYPED, 10'd0, 1'b0},
			'{CMD_DATA,  8'hFF, EXP_PRED, 10'd0, 1'b0},
			'{CMD_DATA,  8'h00, EXP_PRED, 10'd0, 1'b0},
			'{CMD_DATA,  8'hFF, EXP_PRED, 10'd0, 1'b0},
			'{CMD_DATA,  8'hFF, EXP_PRED, 10'd0, 1'b0},
			'{CMD_DATA,  8'h00, EXP_PRED, 10'd0, 1'b0},
			'{CMD_DATA,  8'h00, EXP_PRED, 10'd0, 1'b0},
			'{CMD_DATA,  8'hFF, EXP_PRED, 10'd0, 1'b0},
			'{CMD_DATA,  8'h01, EXP_PRED, 10'd0, 1'b0},
			'{CMD_DATA,  8'hFE, EXP_PRED, 10'd0, 1'b0}
		};
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= CMD_DATA;
		cfg_we <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_data <= '0;
		errors = 0;
		n_items = 0;
		n_results = 0;
		n_rand = 0;
		n_phases = 0;
		burst_left = 0;
		wr_ptr = 0;
		pend = 0;
		center = 0;
		col = 0;
		row = 0;
		frm = 0;
		vw = MAXW;
		vh = MAXH;
		vd = 3;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: smallest volume
		cfg_write(REG_WIDTH, 16'd3);
		cfg_write(REG_HEIGHT, 16'd3);
		cfg_write(REG_DEPTH, 16'd3);
		cfg_write(REG_NONE, 16'hFFFF);
		foreach (dir_tab[i]) begin
			typed.grad = dir_tab[i].grad;
			typed.lst = dir_tab[i].lst;
			send_item(dir_tab[i].cmd, dir_tab[i].vox, dir_tab[i].kind, typed);
		end
		drain_all(1);

		// extremes and clamping
		run_phase(16'd511, 16'd3, 16'd0, 1, 200, 1'b0);
		run_phase(16'd0, 16'd256, 16'd3, 1, 200, 1'b0);
		run_phase(16'hFE03, 16'hFE04, 16'hFFFF, 1, 80, 1'b0);
		run_phase(16'd3, 16'd3, 16'd3, 3, 1 << 20, 1'b0);

		// random phases
		while (n_items < ITEM_GOAL) begin
			left = ITEM_GOAL - n_items;
			cap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 150) : 250;
			if (cap > left) cap = left;
			run_phase(16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(3, 9)),
				16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(3, 7)),
				16'($urandom_range(0, 19) == 0 ? $urandom : $urandom_range(3, 5)),
				$urandom_range(1, 2), cap, 1'b1);
		end

		while (grad_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("covered %0d items (%0d in random phases), %0d results", n_items, n_rand,
			n_results);
		$display("over %0d register settings", n_phases);
		if (errors == 0)
			$display("volume_sobel_max_magnitude_unit_tb: PASS");
		else
			$display("volume_sobel_max_magnitude_unit_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/vsm_pkg.sv
rtl/vsm_ram.sv
rtl/vsm_delay.sv
rtl/volume_sobel_max_magnitude_unit.sv
dv/volume_sobel_max_magnitude_unit_tb.sv
